// ----- hdl/cfca_pkg.sv -----
// Shared constants and types of the contiguous free-chain allocator.
package cfca_pkg;

	localparam int NUM_BLOCKS       = 1024;
	localparam int ROOT_AREA_BLOCKS = 4;

	localparam int BLK_W  = $clog2(NUM_BLOCKS);
	localparam int LINK_W = BLK_W + 1;
	localparam int CNT_W  = LINK_W;

	localparam logic [LINK_W-1:0] CHAIN_END      = LINK_W'(NUM_BLOCKS);
	localparam logic [LINK_W-1:0] FIRST_FREE_BLK = LINK_W'(1 + ROOT_AREA_BLOCKS);
	localparam logic [CNT_W-1:0]  RESET_FREE     = CNT_W'(NUM_BLOCKS - 1 - ROOT_AREA_BLOCKS);
	localparam logic [BLK_W-1:0]  LAST_BLK       = BLK_W'(NUM_BLOCKS - 1);

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_INVALID = 2'd1,
		STAT_TOO_FEW = 2'd2,
		STAT_NO_RUN  = 2'd3
	} status_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_t;

	typedef enum logic [2:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_WALK,
		FSM_FREE,
		FSM_EMIT
	} fsm_t;

endpackage

// ----- hdl/cfca_ram.sv -----
// Generic simple dual-port RAM with registered read.
module cfca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/contiguous_free_chain_allocator.sv -----
// Top level of the contiguous free-chain block allocator.
//
// Usage: requests enter on the s_ stream (tuser = request kind, tdata = count
// and first block), one result per request leaves on the m_ stream.
// The free chain's next-pointer table lives in a RAM with registered read;
// the chain head and free count are registers.
// After reset a clearing pass links every block to its successor, and
// s_tready stays low meanwhile. A rejected request skips the walk.
// An allocate walks the chain one link per cycle through the RAM read
// port; a free writes one link per cycle through the RAM write port.
// One request is worked on at a time; s_tready is high only when idle.
// The result sits in an output register; while the receiver stalls, the
// block still takes a new request and holds its finished result until the
// output register is taken.
module contiguous_free_chain_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [10:0] block_count, [20:11] first_block, rest zero
	input  logic        s_tuser,   // [0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [1:0] status, [11:2] run_start, [22:12] free_total
);
	import cfca_pkg::*;

	fsm_t state_q, state_nxt;

	logic [LINK_W-1:0] head_q;
	logic [CNT_W-1:0]  free_q;
	logic [LINK_W-1:0] idx_q;
	logic [LINK_W-1:0] last_q;
	logic [LINK_W-1:0] curr_q, prev_q, start_q, before_q;
	logic [CNT_W-1:0]  run_len_q, steps_q, n_q;
	status_t           res_status_q;
	logic [BLK_W-1:0]  res_start_q;
	logic              m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic              ram_we;
	logic [BLK_W-1:0]  ram_waddr, ram_raddr;
	logic [LINK_W-1:0] ram_wdata, ram_rdata;

	logic [CNT_W-1:0]  in_count;
	logic [BLK_W-1:0]  in_first;
	logic              in_kind;
	logic              accept;
	logic [CNT_W:0]    free_end;
	logic              free_bad;

	logic              walk_stop, run_hit, run_done;
	logic [CNT_W-1:0]  new_len;
	logic [LINK_W-1:0] new_start, new_before;
	logic [CNT_W:0]    free_sum;
	logic              out_free;

	assign in_count = s_tdata[CNT_W-1:0];
	assign in_first = s_tdata[CNT_W +: BLK_W];
	assign in_kind  = s_tuser;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// free range check
	assign free_end = (CNT_W+1)'(in_first) + (CNT_W+1)'(in_count);
	assign free_bad = (in_count == '0) || (free_end > (CNT_W+1)'(NUM_BLOCKS));

	// walk step decode
	assign walk_stop  = (steps_q == CNT_W'(NUM_BLOCKS)) || (curr_q >= CHAIN_END);
	assign run_hit    = (run_len_q != '0) && (curr_q == start_q + run_len_q);
	assign new_len    = run_hit ? run_len_q + CNT_W'(1) : CNT_W'(1);
	assign new_start  = run_hit ? start_q : curr_q;
	assign new_before = run_hit ? before_q : prev_q;
	assign run_done   = !walk_stop && (new_len == n_q);

	assign free_sum = (CNT_W+1)'(free_q) + (CNT_W+1)'(n_q);

	cfca_ram #(
		.WIDTH(LINK_W),
		.DEPTH(NUM_BLOCKS)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state, RAM control and handshake
	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q[BLK_W-1:0];
		ram_wdata = idx_q + LINK_W'(1);
		ram_raddr = curr_q[BLK_W-1:0];
		unique case (state_q)
			FSM_CLEAR: begin
				ram_we = 1'b1;
				if (idx_q[BLK_W-1:0] == LAST_BLK) begin
					state_nxt = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				s_tready  = 1'b1;
				ram_raddr = head_q[BLK_W-1:0];
				if (s_tvalid) begin
					if (in_kind == REQ_ALLOC) begin
						if (in_count == '0 || in_count > free_q) begin
							state_nxt = FSM_EMIT;
						end else begin
							state_nxt = FSM_WALK;
						end
					end else begin
						state_nxt = free_bad ? FSM_EMIT : FSM_FREE;
					end
				end
			end
			FSM_WALK: begin
				ram_raddr = ram_rdata[BLK_W-1:0];
				if (walk_stop) begin
					state_nxt = FSM_EMIT;
				end else if (run_done) begin
					ram_we    = (new_before < CHAIN_END);
					ram_waddr = new_before[BLK_W-1:0];
					ram_wdata = ram_rdata;
					state_nxt = FSM_EMIT;
				end
			end
			FSM_FREE: begin
				ram_we = 1'b1;
				if (idx_q == last_q) begin
					ram_wdata = head_q;
					state_nxt = FSM_EMIT;
				end
			end
			FSM_EMIT: begin
				if (out_free) begin
					state_nxt = FSM_IDLE;
				end
			end
			default: begin
				state_nxt = FSM_IDLE;
			end
		endcase
	end

	// chain head, free count and sweep index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= FIRST_FREE_BLK;
			free_q <= RESET_FREE;
			idx_q  <= '0;
		end else begin
			case (state_q)
				FSM_CLEAR: begin
					idx_q <= idx_q + LINK_W'(1);
				end
				FSM_IDLE: begin
					idx_q <= LINK_W'(in_first);
				end
				FSM_WALK: begin
					if (run_done) begin
						if (new_before >= CHAIN_END) begin
							head_q <= ram_rdata;
						end
						free_q <= free_q - n_q;
					end
				end
				FSM_FREE: begin
					idx_q <= idx_q + LINK_W'(1);
					if (idx_q == last_q) begin
						head_q <= LINK_W'(start_q);
						free_q <= (free_sum > (CNT_W+1)'(NUM_BLOCKS)) ?
							CNT_W'(NUM_BLOCKS) : free_sum[CNT_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// request and walk payload
	always_ff @(posedge clk) begin
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					n_q          <= in_count;
					curr_q       <= head_q;
					prev_q       <= CHAIN_END;
					start_q      <= LINK_W'(in_first);
					before_q     <= CHAIN_END;
					run_len_q    <= '0;
					steps_q      <= '0;
					last_q       <= LINK_W'(free_end - (CNT_W+1)'(1));
					res_start_q  <= '0;
					res_status_q <= STAT_OK;
					if (in_kind == REQ_ALLOC) begin
						if (in_count == '0) begin
							res_status_q <= STAT_INVALID;
						end else if (in_count > free_q) begin
							res_status_q <= STAT_TOO_FEW;
						end
					end else if (free_bad) begin
						res_status_q <= STAT_INVALID;
					end
				end
			end
			FSM_WALK: begin
				if (walk_stop) begin
					res_status_q <= STAT_NO_RUN;
				end else if (run_done) begin
					res_status_q <= STAT_OK;
					res_start_q  <= new_start[BLK_W-1:0];
				end else begin
					run_len_q <= new_len;
					start_q   <= new_start;
					before_q  <= new_before;
					prev_q    <= curr_q;
					curr_q    <= ram_rdata;
					steps_q   <= steps_q + CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// output register: load in emit when free, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == FSM_EMIT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FSM_EMIT && out_free) begin
			m_tdata_q <= {1'b0, free_q, res_start_q, res_status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
